[src/keyframe_record_and_lerp_playback_unit_macros.svh]
// Assertion macros for the keyframe record and playback unit.
// Included by the modules that carry concurrent assertions.
`ifndef KEYFRAME_RECORD_AND_LERP_PLAYBACK_UNIT_MACROS_SVH
`define KEYFRAME_RECORD_AND_LERP_PLAYBACK_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define KLP_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define KLP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define KLP_ASSERT_IMP(label, clk, rst_n, pre, post)
`define KLP_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[src/klp_pkg.sv]
// Shared types and constants of the keyframe record and playback unit.
// No dependencies.
package klp_pkg;
  localparam int unsigned MaxFramesDef = 1024;
  localparam int unsigned ChanW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned StatusW = 3;

  localparam logic [StatusW-1:0] StStored = 3'd0;
  localparam logic [StatusW-1:0] StFull   = 3'd1;
  localparam logic [StatusW-1:0] StOk     = 3'd2;
  localparam logic [StatusW-1:0] StEmpty  = 3'd3;
  localparam logic [StatusW-1:0] StEnd    = 3'd4;

  localparam logic OpRecord = 1'b0;
  localparam logic OpPlay   = 1'b1;

  // One queued beat between front and back.
  typedef struct packed {
    logic                   op;
    logic [TimeW-1:0]       t;
    logic [6*ChanW-1:0]     ch;
  } cmd_t;
endpackage

[src/keyframe_record_and_lerp_playback_unit.sv]
// Top level of the keyframe record and linear-interpolation playback unit.
// Depends on klp_pkg, klp_front, klp_back and klp_ram.
// A record beat passes from idle through the output state in the back end. A play
// beat walks the cursor over stored frames through the single memory read port,
// then interpolates six channels with a bit-serial divider; exact, first and end
// answers skip the divider. Results appear for one cycle on done_o and
// cannot be held off. A two-beat queue lets start be taken while the back end works.
module keyframe_record_and_lerp_playback_unit #(
  parameter int unsigned MaxFrames = klp_pkg::MaxFramesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      operation_i,
  input  logic [31:0]               time_req_i,
  input  logic signed [31:0]        pos_x_i,
  input  logic signed [31:0]        pos_y_i,
  input  logic signed [31:0]        pos_z_i,
  input  logic signed [31:0]        angle_x_i,
  input  logic signed [31:0]        angle_y_i,
  input  logic signed [31:0]        angle_z_i,
  output logic                      done_o,
  output logic [2:0]                status_o,
  output logic signed [31:0]        out_x_o,
  output logic signed [31:0]        out_y_o,
  output logic signed [31:0]        out_z_o,
  output logic signed [31:0]        out_angle_x_o,
  output logic signed [31:0]        out_angle_y_o,
  output logic signed [31:0]        out_angle_z_o
);
  import klp_pkg::*;

  cmd_t cin, cq;
  logic vq, pop;
  logic [6*ChanW-1:0] ch;

  assign cin.op = operation_i;
  assign cin.t  = time_req_i;
  assign cin.ch = {angle_z_i, angle_y_i, angle_x_i, pos_z_i, pos_y_i, pos_x_i};

  klp_front u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .cmd_i(cin),
    .valid_o(vq), .cmd_o(cq), .pop_i(pop)
  );
  klp_back #(.MaxFrames(MaxFrames)) u_back (
    .clk_i, .rst_ni, .valid_i(vq), .cmd_i(cq), .pop_o(pop),
    .strobe_o(done_o), .status_o(status_o), .ch_o(ch)
  );

  assign out_x_o       = ch[0*ChanW +: ChanW];
  assign out_y_o       = ch[1*ChanW +: ChanW];
  assign out_z_o       = ch[2*ChanW +: ChanW];
  assign out_angle_x_o = ch[3*ChanW +: ChanW];
  assign out_angle_y_o = ch[4*ChanW +: ChanW];
  assign out_angle_z_o = ch[5*ChanW +: ChanW];
endmodule

[src/klp_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module klp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write one word when enabled and read one word every cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[src/klp_front.sv]
// Front end: takes command beats and holds them in a two-entry queue.
// Depends on klp_pkg.
module klp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  klp_pkg::cmd_t cmd_i,
  output logic          valid_o,
  output klp_pkg::cmd_t cmd_o,
  input  logic          pop_i
);
  import klp_pkg::*;

  cmd_t       q_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign busy_o  = (cnt_q == 2'd2);
  assign push    = start_i && !busy_o;
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = q_q[rp_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= cmd_i;
    end
  end

  // Queue pointers and fill.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  `include "keyframe_record_and_lerp_playback_unit_macros.svh"
  `KLP_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, pop_i, cnt_q != 2'd0)
  `KLP_ASSERT_IMP(a_fill_range, clk_i, rst_ni, 1'b1, cnt_q != 2'd3)
  `KLP_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, push && !pop_i, cnt_q != 2'd0)
endmodule

[src/klp_back.sv]
// Back end: frame store, cursor walk and serial interpolation divider.
// Depends on klp_pkg and klp_ram.
module klp_back #(
  parameter int unsigned MaxFrames = klp_pkg::MaxFramesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  klp_pkg::cmd_t                 cmd_i,
  output logic                          pop_o,
  output logic                          strobe_o,
  output logic [klp_pkg::StatusW-1:0]   status_o,
  output logic [6*klp_pkg::ChanW-1:0]   ch_o
);
  import klp_pkg::*;

  localparam int unsigned AW = $clog2(MaxFrames);
  localparam int unsigned CW = $clog2(MaxFrames + 1);
  localparam int unsigned FW = TimeW + 6 * ChanW;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SRd    = 4'd1;
  localparam logic [3:0] SWait  = 4'd2;
  localparam logic [3:0] SChk   = 4'd3;
  localparam logic [3:0] SPrv   = 4'd4;
  localparam logic [3:0] SPrvW  = 4'd5;
  localparam logic [3:0] SLast  = 4'd6;
  localparam logic [3:0] SLastW = 4'd7;
  localparam logic [3:0] SMul   = 4'd8;
  localparam logic [3:0] SDiv   = 4'd9;
  localparam logic [3:0] SFin   = 4'd10;
  localparam logic [3:0] SOut   = 4'd11;

  logic [3:0]          st_q;
  logic [CW-1:0]       cnt_q, cur_q;
  logic                we;
  logic [AW-1:0]       addr;
  logic [FW-1:0]       rdata;
  logic [FW-1:0]       cur_f_q, prv_f_q;
  logic [2:0]          k_q;
  logic [StatusW-1:0]  stat_q;
  logic [6*ChanW-1:0]  res_q;
  logic                neg_q;
  logic [64:0]         rem_q;
  logic [64:0]         quo_q;
  logic [32:0]         den_q;
  logic [6:0]          bit_q;
  logic [32:0]         ad_q, adv_q;

  // Frame store: time in the low word, channels above it.
  assign we = (st_q == SIdle) && valid_i && (cmd_i.op == OpRecord) &&
              (cnt_q < CW'(MaxFrames));
  always_comb begin
    addr = cur_q[AW-1:0];
    if (we) addr = cnt_q[AW-1:0];
    else if (st_q == SPrv) addr = AW'(cur_q - 1'b1);
    else if (st_q == SLast) addr = AW'(cnt_q - 1'b1);
  end
  klp_ram #(.Width(FW), .Depth(MaxFrames)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i({cmd_i.ch, cmd_i.t}), .rdata_o(rdata)
  );

  logic [TimeW-1:0] tq;
  assign tq = cmd_i.t;
  logic [TimeW-1:0] ct;
  assign ct = cur_f_q[TimeW-1:0];
  logic [TimeW-1:0] pt;
  assign pt = prv_f_q[TimeW-1:0];
  logic signed [ChanW-1:0] v1, v2;
  assign v1 = prv_f_q[TimeW + k_q*ChanW +: ChanW];
  assign v2 = cur_f_q[TimeW + k_q*ChanW +: ChanW];
  logic signed [32:0] dd, ddv, dden;
  assign dd   = $signed({1'b0, ct}) - $signed({1'b0, tq});
  assign ddv  = 33'(v2) - 33'(v1);
  assign dden = $signed({1'b0, pt}) - $signed({1'b0, ct});
  logic [65:0] prod;
  assign prod = ad_q * adv_q;
  logic [65:0] trial;
  assign trial = {rem_q, quo_q[64]} - {33'd0, den_q};
  logic signed [35:0] sum;
  logic [33:0] qs;
  assign qs = (quo_q > 65'h1FFFFFFFF) ? 34'h200000000 : quo_q[33:0];
  assign sum = 36'(v2) + (neg_q ? -$signed({2'b0, qs}) : $signed({2'b0, qs}));

  // Sequencer: one queued beat at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0; cur_q <= '0; strobe_o <= 1'b0; k_q <= '0;
    end else begin
      strobe_o <= 1'b0;
      case (st_q)
        SIdle: if (valid_i) begin
          res_q <= '0;
          if (cmd_i.op == OpRecord) begin
            if (we) begin cnt_q <= cnt_q + 1'b1; stat_q <= StStored; end
            else stat_q <= StFull;
            st_q <= SOut;
          end else if (cnt_q == '0) begin
            stat_q <= StEmpty; st_q <= SOut;
          end else st_q <= (cur_q < cnt_q) ? SRd : SLast;
        end
        SRd:  st_q <= SWait;
        SWait: begin cur_f_q <= rdata; st_q <= SChk; end
        SChk: if (ct < tq) begin
          cur_q <= cur_q + 1'b1;
          st_q  <= (cur_q + 1'b1 < cnt_q) ? SRd : SLast;
        end else if (cur_q == '0 || ct == tq) begin
          res_q <= cur_f_q[FW-1:TimeW]; stat_q <= StOk; st_q <= SOut;
        end else st_q <= SPrv;
        SPrv:  st_q <= SPrvW;
        SPrvW: begin prv_f_q <= rdata; k_q <= '0; stat_q <= StOk; st_q <= SMul; end
        SLast: st_q <= SLastW;
        SLastW: begin res_q <= rdata[FW-1:TimeW]; stat_q <= StEnd; st_q <= SOut; end
        SMul: begin
          ad_q  <= dd[32] ? 33'(-dd) : 33'(dd);
          adv_q <= ddv[32] ? 33'(-ddv) : 33'(ddv);
          den_q <= dden[32] ? 33'(-dden) : 33'(dden);
          neg_q <= dd[32] ^ ddv[32] ^ dden[32];
          st_q  <= SDiv; bit_q <= 7'd0;
          if (dden == '0) begin
            res_q[k_q*ChanW +: ChanW] <= v2;
            k_q  <= k_q + 1'b1;
            st_q <= (k_q == 3'd5) ? SOut : SMul;
          end
        end
        SDiv: begin
          // Restoring divide, one quotient bit per cycle.
          if (bit_q == 7'd0) begin
            quo_q <= prod[64:0]; rem_q <= '0; bit_q <= 7'd1;
          end else begin
            if (!trial[65]) begin
              rem_q <= trial[64:0]; quo_q <= {quo_q[63:0], 1'b1};
            end else begin
              rem_q <= {rem_q[63:0], quo_q[64]}; quo_q <= {quo_q[63:0], 1'b0};
            end
            bit_q <= bit_q + 1'b1;
            if (bit_q == 7'd65) st_q <= SFin;
          end
        end
        SFin: begin
          res_q[k_q*ChanW +: ChanW] <= (sum > 36'sd2147483647) ? 32'h7FFFFFFF :
                                       (sum < -36'sd2147483648) ? 32'h80000000 : sum[31:0];
          k_q  <= k_q + 1'b1;
          st_q <= (k_q == 3'd5) ? SOut : SMul;
        end
        SOut: begin strobe_o <= 1'b1; st_q <= SIdle; end
        default: st_q <= SIdle;
      endcase
    end
  end

  assign pop_o    = (st_q == SOut);
  assign status_o = stat_q;
  assign ch_o     = res_q;

  `include "keyframe_record_and_lerp_playback_unit_macros.svh"
  `KLP_ASSERT_IMP(a_cur_bound, clk_i, rst_ni, 1'b1, cur_q <= cnt_q)
  `KLP_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(MaxFrames))
  `KLP_ASSERT_NEXT(a_pop_strobe, clk_i, rst_ni, pop_o, strobe_o)
endmodule
